// ===== hdl/ade_pkg.sv =====
// Shared types and constants for the array deque engine.
`default_nettype none

package ade_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK         = 2'd0,
    ST_FULL_LEFT  = 2'd1,
    ST_FULL_RIGHT = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic exec;   // execute the accepted command this cycle
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ade_if.sv =====
// Valid/ready channel interfaces for commands and results.
`default_nettype none

interface ade_in_if;
  import ade_pkg::*;
  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     cmd;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface ade_out_if;
  import ade_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [ValueW-1:0] data;
  logic [StatW-1:0]    status;
  logic [CountW-1:0]   count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink   (input valid, input data, input status, input count, output ready);
endinterface

`default_nettype wire

// ===== hdl/ade_ctrl.sv =====
// Handshake controller: accepts one command, then holds its result beat.
`default_nettype none

module ade_ctrl
  import ade_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output ctrl_cmd_t      ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl_o.exec = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.exec = in_valid_i;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ade_dp.sv =====
// Deque datapath: head/tail indices, slot memory and result registers.
`default_nettype none

module ade_dp
  import ade_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ctrl_cmd_t                ctrl_i,
  input  wire logic [CmdW-1:0]          cmd_i,
  input  wire logic signed [ValueW-1:0] value_i,
  output logic signed [ValueW-1:0]      data_o,
  output logic [StatW-1:0]              status_o,
  output logic [CountW-1:0]             count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic          empty_q, empty_d;
  status_e       stat_q, stat_d;
  logic          popped_q, popped_d;
  logic [CountW-1:0] count_q;
  logic [AW:0]   span;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [ValueW-1:0] mem [DEPTH];
  logic [ValueW-1:0] rd_q;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    stat_d   = ST_OK;
    popped_d = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    rd_en    = 1'b0;
    rd_addr  = head_q;
    case (cmd_e'(cmd_i))
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (empty_q) begin
          // first element always lands in slot 0
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
          wr_en   = 1'b1;
        end else if (cmd_e'(cmd_i) == CMD_PUSH_FRONT) begin
          if (head_q == '0) begin
            stat_d = ST_FULL_LEFT;
          end else begin
            head_d  = head_q - 1'b1;
            wr_en   = 1'b1;
            wr_addr = head_q - 1'b1;
          end
        end else begin
          if (tail_q == LastIdx) begin
            stat_d = ST_FULL_RIGHT;
          end else begin
            tail_d  = tail_q + 1'b1;
            wr_en   = 1'b1;
            wr_addr = tail_q + 1'b1;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty_q) begin
          stat_d = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          popped_d = 1'b1;
          rd_addr  = (cmd_e'(cmd_i) == CMD_POP_FRONT) ? head_q : tail_q;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else if (cmd_e'(cmd_i) == CMD_POP_FRONT) begin
            head_d = head_q + 1'b1;
          end else begin
            tail_d = tail_q - 1'b1;
          end
        end
      end
      default: stat_d = ST_OK;
    endcase
  end

  assign span = {1'b0, tail_d} - {1'b0, head_d} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      stat_q   <= ST_OK;
      popped_q <= 1'b0;
      count_q  <= '0;
    end else if (ctrl_i.exec) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      stat_q   <= stat_d;
      popped_q <= popped_d;
      count_q  <= empty_d ? '0 : CountW'(span);
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && wr_en) mem[wr_addr] <= value_i;
    if (ctrl_i.exec && rd_en) rd_q <= mem[rd_addr];
  end

  assign data_o   = popped_q ? $signed(rd_q) : '0;
  assign status_o = stat_q;
  assign count_o  = count_q;

endmodule

`default_nettype wire

// ===== hdl/array_deque_engine.sv =====
// Top level of the array deque engine.
//
//   channel | dir | payload               | beat
//   in_i    | in  | cmd[1:0], value[31:0] | one command
//   out_o   | out | data, status, count   | one result per command
//
// Each command is accepted first, then its result beat is offered.
// The next command is taken the cycle after the result beat is taken; the
// controller holds in_i.ready low while a result beat is pending.
// Reset (rst_ni low) empties the deque; slot contents are not cleared.
// A stalled result holds until out_o.ready; no command is taken meanwhile.
`default_nettype none

module array_deque_engine
  import ade_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ade_in_if.sink     in_i,
  ade_out_if.source  out_o
);

  ctrl_cmd_t ctrl;

  ade_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  ade_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cmd_i    (in_i.cmd),
    .value_i  (in_i.value),
    .data_o   (out_o.data),
    .status_o (out_o.status),
    .count_o  (out_o.count)
  );

endmodule

`default_nettype wire
